FILE: src/rau_pkg.sv
// shared types and constants of the rational arithmetic unit
package rau_pkg;

    localparam int unsigned FIELD_W = 32;
    localparam int unsigned PROD_W  = 2 * FIELD_W;
    localparam int unsigned ALU_W   = PROD_W + 1;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;
    localparam logic [1:0] MODE_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]                 mode;
        logic signed [FIELD_W-1:0]  a_num;
        logic signed [FIELD_W-1:0]  a_den;
        logic signed [FIELD_W-1:0]  b_num;
        logic signed [FIELD_W-1:0]  b_den;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0]  res_num;
        logic [FIELD_W-2:0]         res_den;
        logic [1:0]                 status;
    } t_out_item;

    typedef struct packed {
        logic               borrow;
        logic [ALU_W-1:0]   value;
    } t_alu_res;

endpackage

FILE: src/rau_mul.sv
// 32 by 32 unsigned multiplier with registered product
module rau_mul (
    input  logic                            i_clk,
    input  logic [rau_pkg::FIELD_W-1:0]     i_a,
    input  logic [rau_pkg::FIELD_W-1:0]     i_b,
    output logic [rau_pkg::PROD_W-1:0]      o_prod
);
    import rau_pkg::*;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: src/rau_alu.sv
// shared 65-bit add / subtract unit with borrow out, used by sum, gcd and divide steps
module rau_alu (
    input  logic [rau_pkg::ALU_W-1:0]   i_a,
    input  logic [rau_pkg::ALU_W-1:0]   i_b,
    input  logic                        i_sub,
    output rau_pkg::t_alu_res           o_res
);
    import rau_pkg::*;

    logic [ALU_W:0] w_full;

    always_comb begin
        w_full = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + (ALU_W + 1)'(i_sub);
        o_res.value  = w_full[ALU_W-1:0];
        o_res.borrow = i_sub & ~w_full[ALU_W];
    end

endmodule

FILE: src/rational_arith_unit_top.sv
// top level of the rational arithmetic unit: sequencer and datapath registers
//
//  channel   | handshake        | payload                     | direction
//  ----------+------------------+-----------------------------+----------
//  command   | start / busy     | i_item   (rau_pkg::t_in_item)  | in
//  result    | o_valid strobe   | o_result (rau_pkg::t_out_item) | out
//
//  an item is taken when start is high and busy is low; busy stays high until the
//  strobe of its result, which comes with busy low again, one item in flight at a time
//  steps per item: a zero denominator goes straight to the result step; a zero
//  numerator takes the products, in add and sub modes the add/subtract (with a swap
//  when the second term is larger), the set-up and the range check; otherwise the
//  binary gcd and two bit-serial divides by the gcd come between set-up and check;
//  the strobe follows the range check; sum, gcd and divides all use one 65-bit adder
//  synchronous active-low reset clears the sequencer and the strobe only
//  the result strobe lasts one cycle and cannot be held off by the receiver
module rational_arith_unit_top #(
    parameter int unsigned WORD_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  rau_pkg::t_in_item   i_item,
    output logic                busy,
    output logic                o_valid,
    output rau_pkg::t_out_item  o_result
);
    import rau_pkg::*;

    // largest magnitude a reduced numerator may have when negative
    localparam logic [PROD_W-1:0] LIM = PROD_W'(1) << (WORD_WIDTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_PREP,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_CHECK
    } t_state;

    t_state             r_state;
    logic [5:0]         r_cnt;
    logic [1:0]         r_mode;
    logic               r_err;
    // operand magnitudes
    logic [FIELD_W-1:0] r_an, r_ad, r_bn, r_bd;
    // sign of first product / numerator, second product, denominator
    logic               r_ps, r_qs, r_ds;
    // numerator, denominator and second cross product magnitudes
    logic [PROD_W-1:0]  r_nm, r_dm, r_t;
    // gcd working pair, common power of two, final gcd
    logic [PROD_W-1:0]  r_gx, r_gy, r_g;
    logic [5:0]         r_k;
    logic [PROD_W-1:0]  r_rem;
    logic               r_valid;
    t_out_item          r_result;

    // input magnitudes and signs
    logic [FIELD_W-1:0] n_an, n_ad, n_bn, n_bd;
    logic               an_s, ad_s, bn_s, bd_s;
    logic               zero_den;

    // shared units
    logic [FIELD_W-1:0] mul_a, mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [ALU_W-1:0]   alu_a, alu_b;
    logic               alu_sub;
    t_alu_res           alu_res;

    // result check
    logic               res_neg;
    logic               ovf;

    always_comb begin
        an_s = i_item.a_num[FIELD_W-1];
        ad_s = i_item.a_den[FIELD_W-1];
        bn_s = i_item.b_num[FIELD_W-1];
        bd_s = i_item.b_den[FIELD_W-1];
        n_an = an_s ? (~i_item.a_num + FIELD_W'(1)) : i_item.a_num;
        n_ad = ad_s ? (~i_item.a_den + FIELD_W'(1)) : i_item.a_den;
        n_bn = bn_s ? (~i_item.b_num + FIELD_W'(1)) : i_item.b_num;
        n_bd = bd_s ? (~i_item.b_den + FIELD_W'(1)) : i_item.b_den;
        zero_den = (i_item.a_den == '0) || (i_item.b_den == '0) ||
                   ((i_item.mode == MODE_DIV) && (i_item.b_num == '0));
    end

    // product schedule: numerator term, denominator, second cross term
    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                mul_a = r_an;
                mul_b = (r_mode == MODE_MUL) ? r_bn : r_bd;
            end
            2'd1: begin
                mul_a = r_ad;
                mul_b = (r_mode == MODE_DIV) ? r_bn : r_bd;
            end
            default: begin
                mul_a = r_bn;
                mul_b = r_ad;
            end
        endcase
    end

    rau_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    // operand routing into the shared add / subtract unit
    always_comb begin
        alu_a   = {1'b0, r_gx};
        alu_b   = {1'b0, r_gy};
        alu_sub = 1'b1;
        case (r_state)
            S_SUM: begin
                alu_a   = {1'b0, r_nm};
                alu_b   = {1'b0, r_t};
                alu_sub = (r_ps != r_qs);
            end
            S_DIVN: begin
                alu_a = {r_rem, r_nm[PROD_W-1]};
                alu_b = {1'b0, r_g};
            end
            S_DIVD: begin
                alu_a = {r_rem, r_dm[PROD_W-1]};
                alu_b = {1'b0, r_g};
            end
            default: begin
                alu_a   = {1'b0, r_gx};
                alu_b   = {1'b0, r_gy};
                alu_sub = 1'b1;
            end
        endcase
    end

    rau_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_res (alu_res)
    );

    // range check of the reduced fraction
    always_comb begin
        res_neg = r_ps ^ r_ds;
        ovf = (r_dm >= LIM) || (res_neg ? (r_nm > LIM) : (r_nm >= LIM));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mode <= i_item.mode;
                        r_an   <= n_an;
                        r_ad   <= n_ad;
                        r_bn   <= n_bn;
                        r_bd   <= n_bd;
                        r_ps   <= (i_item.mode == MODE_MUL) ? (an_s ^ bn_s) : (an_s ^ bd_s);
                        r_qs   <= bn_s ^ ad_s ^ (i_item.mode == MODE_SUB);
                        r_ds   <= (i_item.mode == MODE_DIV) ? (ad_s ^ bn_s) : (ad_s ^ bd_s);
                        r_err  <= zero_den;
                        r_cnt  <= '0;
                        r_state <= zero_den ? S_CHECK : S_MUL;
                    end
                end
                S_MUL: begin
                    r_cnt <= r_cnt + 6'd1;
                    case (r_cnt[1:0])
                        2'd1:    r_nm <= mul_p;
                        2'd2:    r_dm <= mul_p;
                        2'd3:    r_t  <= mul_p;
                        default: ;
                    endcase
                    if (r_cnt[1:0] == 2'd3) begin
                        r_state <= (r_mode inside {MODE_ADD, MODE_SUB}) ? S_SUM : S_PREP;
                    end
                end
                S_SUM: begin
                    if (!alu_res.borrow) begin
                        r_nm    <= alu_res.value[PROD_W-1:0];
                        r_state <= S_PREP;
                    end else begin
                        // second term is larger: swap and subtract the other way
                        r_nm <= r_t;
                        r_t  <= r_nm;
                        r_ps <= r_qs;
                        r_qs <= r_ps;
                    end
                end
                S_PREP: begin
                    if (r_nm == '0) begin
                        // zero reduces to 0/1 with no sign
                        r_dm    <= PROD_W'(1);
                        r_ds    <= r_ps;
                        r_state <= S_CHECK;
                    end else begin
                        r_gx    <= r_nm;
                        r_gy    <= r_dm;
                        r_k     <= '0;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_gx == '0 || r_gy == '0) begin
                        r_g     <= (r_gx | r_gy) << r_k;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIVN;
                    end else if (!r_gx[0] && !r_gy[0]) begin
                        r_gx <= r_gx >> 1;
                        r_gy <= r_gy >> 1;
                        r_k  <= r_k + 6'd1;
                    end else if (!r_gx[0]) begin
                        r_gx <= r_gx >> 1;
                    end else if (!r_gy[0]) begin
                        r_gy <= r_gy >> 1;
                    end else if (alu_res.borrow) begin
                        r_gx <= r_gy;
                        r_gy <= r_gx;
                    end else begin
                        r_gx <= alu_res.value[PROD_W:1];
                    end
                end
                S_DIVN: begin
                    r_nm  <= {r_nm[PROD_W-2:0], ~alu_res.borrow};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(PROD_W - 1)) begin
                        r_rem   <= '0;
                        r_state <= S_DIVD;
                    end else begin
                        r_rem <= alu_res.borrow ? alu_a[PROD_W-1:0]
                                                : alu_res.value[PROD_W-1:0];
                    end
                end
                S_DIVD: begin
                    r_rem <= alu_res.borrow ? alu_a[PROD_W-1:0] : alu_res.value[PROD_W-1:0];
                    r_dm  <= {r_dm[PROD_W-2:0], ~alu_res.borrow};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(PROD_W - 1)) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                    if (r_err) begin
                        r_result.res_num <= '0;
                        r_result.res_den <= '0;
                        r_result.status  <= ST_ZERO_DEN;
                    end else if (ovf) begin
                        r_result.res_num <= '0;
                        r_result.res_den <= '0;
                        r_result.status  <= ST_OVERFLOW;
                    end else begin
                        r_result.res_num <= res_neg ? (~r_nm[FIELD_W-1:0] + FIELD_W'(1))
                                                    : r_nm[FIELD_W-1:0];
                        r_result.res_den <= r_dm[FIELD_W-2:0];
                        r_result.status  <= ST_OK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: src/rau_checker.sv
// port-level checks of the rational arithmetic unit and their bind
module rau_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_valid,
    input rau_pkg::t_out_item   o_result
);
    import rau_pkg::*;

    // an accepted item keeps the unit busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // a result only ends a busy period
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result strobe without a preceding busy period");

    // a result strobe is never followed directly by another
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // legal status codes, a positive denominator on success and a zero one on either error
    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_result.status == ST_OK && o_result.res_den != '0) ||
                     (o_result.status == ST_ZERO_DEN && o_result.res_den == '0) ||
                     (o_result.status == ST_OVERFLOW && o_result.res_den == '0)))
        else $error("bad status or denominator on result");

endmodule

bind rational_arith_unit_top rau_checker u_rau_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
